// ----- src/gts_pkg.sv -----
// shared types and constants of the grid trilinear sampler
`timescale 1ns / 1ps
package gts_pkg;

    // grid geometry
    localparam int CELLS_AXIS1 = 32;
    localparam int CELLS_AXIS2 = 32;
    localparam int CELLS_AXIS3 = 16;
    localparam int FIELD_COUNT = 8;

    localparam int IDX1_W      = 5;
    localparam int IDX2_W      = 5;
    localparam int IDX3_W      = 4;
    localparam int FIELD_W     = 3;
    localparam int ADDR_W      = FIELD_W + IDX1_W + IDX2_W + IDX3_W;
    localparam int STORE_WORDS = FIELD_COUNT * CELLS_AXIS1 * CELLS_AXIS2 * CELLS_AXIS3;

    // axis 3 remainder unit: two bits of the 32-bit magnitude per cycle
    localparam int DIV_STEPS   = 16;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN1 = 3'd0,
        CFG_ORIGIN2 = 3'd1,
        CFG_INV1    = 3'd2,
        CFG_INV2    = 3'd3,
        CFG_INV3    = 3'd4,
        CFG_PERIOD3 = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] origin_axis1;
        logic signed [31:0] origin_axis2;
        logic [30:0]        inv_spacing1;
        logic [30:0]        inv_spacing2;
        logic [30:0]        inv_spacing3;
        logic [30:0]        wrap_period3;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [2:0]         field_sel;
        logic [4:0]         load_i;
        logic [4:0]         load_j;
        logic [3:0]         load_k;
        logic signed [31:0] load_value;
        logic signed [31:0] coord1;
        logic signed [31:0] coord2;
        logic signed [31:0] coord3;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [4:0]         base_i;
        logic [4:0]         base_j;
        logic [3:0]         base_k;
        logic [16:0]        frac1;
        logic [16:0]        frac2;
        logic [16:0]        frac3;
    } result_t;

    // one classified item travelling from front to back
    typedef struct packed {
        logic               is_query;
        logic               field_ok;
        logic [FIELD_W-1:0] field;
        logic [IDX1_W-1:0]  i;
        logic [IDX2_W-1:0]  j;
        logic [IDX3_W-1:0]  k;
        logic [31:0]        value;
        logic [16:0]        frac1;
        logic [16:0]        frac2;
        logic [16:0]        frac3;
    } cmd_t;

endpackage

// ----- src/grid_trilinear_sampler.sv -----
// Top level of the grid trilinear sampler: config registers, front, queue, back.
// A load item is queued on acceptance and written to the grid when the idle back pops it.
// A query passes the front's steps (the 2-bit-per-cycle axis 3 remainder unit, fix,
// multiply, locate), then the queue and the back; the front takes no new item until idle.
// The back reads 8 corners from one single-ported grid memory.
// rst_n clears control and config; grid contents are undefined until loaded.
`timescale 1ns / 1ps
module grid_trilinear_sampler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gts_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output gts_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import gts_pkg::*;

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t q_head;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_axis1 <= '0;
            cfg_reg.origin_axis2 <= '0;
            cfg_reg.inv_spacing1 <= 31'd65536;
            cfg_reg.inv_spacing2 <= 31'd65536;
            cfg_reg.inv_spacing3 <= 31'd65536;
            cfg_reg.wrap_period3 <= 31'd1048576;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN1: cfg_reg.origin_axis1 <= cfg_data;
                CFG_ORIGIN2: cfg_reg.origin_axis2 <= cfg_data;
                CFG_INV1:    cfg_reg.inv_spacing1 <= cfg_data[30:0];
                CFG_INV2:    cfg_reg.inv_spacing2 <= cfg_data[30:0];
                CFG_INV3:    cfg_reg.inv_spacing3 <= cfg_data[30:0];
                CFG_PERIOD3: cfg_reg.wrap_period3 <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    gts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    gts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    gts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

// ----- src/gts_queue.sv -----
// small command queue between the front and the back
`timescale 1ns / 1ps
module gts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gts_pkg::cmd_t push_cmd,
    input  logic          pop,
    output gts_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import gts_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head  = q_mem[rd_ptr_reg];
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/gts_front.sv -----
// front: accepts items, wraps axis 3 and locates the base cell of a query
`timescale 1ns / 1ps
module gts_front (
    input  logic           clk,
    input  logic           rst_n,
    input  gts_pkg::cfg_t  cfg,
    input  logic           start,
    input  gts_pkg::item_t item,
    output logic           busy,
    output logic           push,
    output gts_pkg::cmd_t  push_cmd,
    input  logic           q_full
);
    import gts_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV  = 5'b00010,
        F_FIX  = 5'b00100,
        F_MUL  = 5'b01000,
        F_LOC  = 5'b10000
    } fstate_t;

    typedef struct packed {
        logic [9:0]  base;
        logic [16:0] frac;
    } loc_t;

    // floor of the scaled position minus one half, clamped to the grid
    function automatic loc_t locate(input logic signed [64:0] prod, input int cells);
        logic signed [64:0] t;
        logic signed [32:0] b;
        loc_t               r;
        t = prod - 65'sd2147483648;
        b = t[64:32];
        if (b < 33'sd0)
        begin
            r.base = '0;
            r.frac = '0;
        end
        else if (b > 33'(cells - 2))
        begin
            r.base = 10'(cells - 2);
            r.frac = 17'd65536;
        end
        else
        begin
            r.base = b[9:0];
            r.frac = {1'b0, t[31:16]};
        end
        return r;
    endfunction

    fstate_t            state_reg;
    item_t              item_reg;
    logic               neg_reg;
    logic [31:0]        dvd_reg;
    logic [30:0]        rem_reg;
    logic [3:0]         cnt_reg;
    logic signed [31:0] phi_reg;
    logic signed [64:0] prod1_reg;
    logic signed [64:0] prod2_reg;
    logic signed [64:0] prod3_reg;

    logic               accept;
    logic [31:0]        mag;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [30:0]        rem_a;
    logic [30:0]        rem_b;
    logic [31:0]        period_ext;
    logic signed [32:0] rel1;
    logic signed [32:0] rel2;
    logic signed [32:0] rel3;
    loc_t               loc1;
    loc_t               loc2;
    loc_t               loc3;
    logic               field_ok;
    logic               load_ok;

    assign busy   = (state_reg != F_IDLE) || q_full;
    assign accept = start && !busy;
    assign mag    = item.coord3[31] ? 32'(-item.coord3) : item.coord3;

    // two restoring remainder steps per cycle
    always_comb
    begin
        period_ext = {1'b0, cfg.wrap_period3};
        r_a        = {rem_reg, dvd_reg[31]};
        rem_a      = (r_a >= period_ext) ? 31'(r_a - period_ext) : r_a[30:0];
        r_b        = {rem_a, dvd_reg[30]};
        rem_b      = (r_b >= period_ext) ? 31'(r_b - period_ext) : r_b[30:0];
    end

    // offsets from the grid start
    assign rel1 = $signed({item_reg.coord1[31], item_reg.coord1})
                - $signed({cfg.origin_axis1[31], cfg.origin_axis1});
    assign rel2 = $signed({item_reg.coord2[31], item_reg.coord2})
                - $signed({cfg.origin_axis2[31], cfg.origin_axis2});
    assign rel3 = $signed({phi_reg[31], phi_reg});

    assign loc1 = locate(prod1_reg, CELLS_AXIS1);
    assign loc2 = locate(prod2_reg, CELLS_AXIS2);
    assign loc3 = locate(prod3_reg, CELLS_AXIS3);

    assign field_ok = (int'(item.field_sel) < FIELD_COUNT);
    assign load_ok  = field_ok && (int'(item.load_i) < CELLS_AXIS1)
                    && (int'(item.load_j) < CELLS_AXIS2) && (int'(item.load_k) < CELLS_AXIS3);

    // command towards the back
    always_comb
    begin
        push_cmd = '0;
        push     = 1'b0;
        if (state_reg == F_LOC)
        begin
            push              = !q_full;
            push_cmd.is_query = 1'b1;
            push_cmd.field_ok = (int'(item_reg.field_sel) < FIELD_COUNT);
            push_cmd.field    = item_reg.field_sel;
            push_cmd.i        = IDX1_W'(loc1.base);
            push_cmd.j        = IDX2_W'(loc2.base);
            push_cmd.k        = IDX3_W'(loc3.base);
            push_cmd.frac1    = loc1.frac;
            push_cmd.frac2    = loc2.frac;
            push_cmd.frac3    = loc3.frac;
        end
        else
        begin
            push              = accept && !item.mode;
            push_cmd.is_query = 1'b0;
            push_cmd.field_ok = load_ok;
            push_cmd.field    = item.field_sel;
            push_cmd.i        = item.load_i;
            push_cmd.j        = item.load_j;
            push_cmd.k        = item.load_k;
            push_cmd.value    = item.load_value;
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept && item.mode)
                begin
                    item_reg <= item;
                    neg_reg  <= item.coord3[31];
                    dvd_reg  <= mag;
                    rem_reg  <= '0;
                end
            end
            F_DIV:
            begin
                rem_reg <= rem_b;
                dvd_reg <= {dvd_reg[29:0], 2'b00};
            end
            F_FIX:
            begin
                if (cfg.wrap_period3 == '0)
                begin
                    phi_reg <= item_reg.coord3;
                end
                else if (neg_reg && (rem_reg != '0))
                begin
                    phi_reg <= $signed({1'b0, 31'(cfg.wrap_period3 - rem_reg)});
                end
                else
                begin
                    phi_reg <= $signed({1'b0, rem_reg});
                end
            end
            F_MUL:
            begin
                prod1_reg <= rel1 * $signed({1'b0, cfg.inv_spacing1});
                prod2_reg <= rel2 * $signed({1'b0, cfg.inv_spacing2});
                prod3_reg <= rel3 * $signed({1'b0, cfg.inv_spacing3});
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && item.mode)
                    begin
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'(DIV_STEPS - 1))
                    begin
                        state_reg <= F_FIX;
                    end
                end
                F_FIX:   state_reg <= F_MUL;
                F_MUL:   state_reg <= F_LOC;
                F_LOC:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- src/gts_back.sv -----
// back: grid memory, corner reads and the trilinear blend
`timescale 1ns / 1ps
module gts_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  gts_pkg::cmd_t    q_head,
    output logic             pop,
    output logic             done,
    output gts_pkg::result_t result
);
    import gts_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_RUN  = 4'b0010,
        B_MIX  = 4'b0100,
        B_SUM  = 4'b1000
    } bstate_t;

    logic [31:0]        mem [STORE_WORDS];
    logic [31:0]        rdata_reg;

    bstate_t            state_reg;
    cmd_t               cur_reg;
    logic [3:0]         cnt_reg;
    logic [32:0]        w_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic signed [49:0] mlo_reg;
    logic signed [49:0] mhi_reg;
    logic               done_reg;
    result_t            result_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [2:0]         corner;
    logic [16:0]        wi;
    logic [16:0]        wj;
    logic signed [64:0] acc_sum;
    logic signed [64:0] acc_rnd;
    logic signed [50:0] mix_sum;
    logic signed [34:0] mix_sh;
    logic signed [31:0] sat;

    assign pop    = (state_reg == B_IDLE) && !q_empty;
    assign mem_we = pop && !q_head.is_query && q_head.field_ok;
    assign corner = cnt_reg[2:0];

    // load address on a pop, corner address while running
    always_comb
    begin
        if (state_reg == B_IDLE)
        begin
            mem_addr = {q_head.field, q_head.i, q_head.j, q_head.k};
        end
        else
        begin
            mem_addr = {cur_reg.field,
                        IDX1_W'(cur_reg.i + IDX1_W'(corner[1])),
                        IDX2_W'(cur_reg.j + IDX2_W'(corner[0])),
                        IDX3_W'(cur_reg.k + IDX3_W'(corner[2]))};
        end
    end

    // single port grid memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= q_head.value;
        end
        rdata_reg <= mem[mem_addr];
    end

    // corner weights
    assign wi = corner[1] ? cur_reg.frac1 : 17'(17'd65536 - cur_reg.frac1);
    assign wj = corner[0] ? cur_reg.frac2 : 17'(17'd65536 - cur_reg.frac2);

    // layer accumulation and final blend
    assign acc_sum = 65'(acc_reg) + 65'(prod_reg);
    assign acc_rnd = acc_sum + 65'sd2147483648;
    assign mix_sum = 51'(mlo_reg) + 51'(mhi_reg) + 51'sd32768;
    assign mix_sh  = mix_sum[50:16];

    always_comb
    begin
        if (mix_sh > 35'sd2147483647)
        begin
            sat = 32'sh7FFFFFFF;
        end
        else if (mix_sh < -35'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = mix_sh[31:0];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
            acc_reg <= '0;
        end
        if (state_reg == B_RUN)
        begin
            if (cnt_reg < 4'd8)
            begin
                w_reg <= 33'(wi * wj);
            end
            if ((cnt_reg >= 4'd1) && (cnt_reg <= 4'd8))
            begin
                prod_reg <= 64'($signed(rdata_reg) * $signed({1'b0, w_reg}));
            end
            if (cnt_reg >= 4'd2)
            begin
                if (cnt_reg == 4'd5)
                begin
                    lo_reg  <= acc_rnd[63:32];
                    acc_reg <= '0;
                end
                else if (cnt_reg == 4'd9)
                begin
                    hi_reg  <= acc_rnd[63:32];
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_sum[63:0];
                end
            end
        end
        if (state_reg == B_MIX)
        begin
            mlo_reg <= lo_reg * $signed({1'b0, 17'(17'd65536 - cur_reg.frac3)});
            mhi_reg <= hi_reg * $signed({1'b0, cur_reg.frac3});
        end
        if (state_reg == B_SUM)
        begin
            result_reg.sample <= cur_reg.field_ok ? sat : 32'sd0;
            result_reg.base_i <= cur_reg.i;
            result_reg.base_j <= cur_reg.j;
            result_reg.base_k <= cur_reg.k;
            result_reg.frac1  <= cur_reg.frac1;
            result_reg.frac2  <= cur_reg.frac2;
            result_reg.frac3  <= cur_reg.frac3;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    cnt_reg <= '0;
                    if (pop && q_head.is_query)
                    begin
                        state_reg <= B_RUN;
                    end
                end
                B_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd9)
                    begin
                        state_reg <= B_MIX;
                    end
                end
                B_MIX:   state_reg <= B_SUM;
                B_SUM:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a result only follows the blend step
    a_done_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == B_SUM))
        else $error("result strobe without a finished blend");

    // loads never disturb a query in flight
    a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == B_IDLE))
        else $error("grid write while a query runs");

    // the corner sweep hands over to the mix step when its count reaches 9
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RUN && cnt_reg == 4'd9) |=> (state_reg == B_MIX))
        else $error("corner sweep did not end");

endmodule
